[rtl/tcq_pkg.sv]
// Package for the two-class detection size qualifier.
// Class codes, register indexes, reset values and shared types; no dependencies.
package tcq_pkg;

	localparam int PIXEL_BITS_DEF = 12;
	localparam int QUEUE_DEPTH    = 2;

	localparam int CFG_DATA_W = 16;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_MIN_HEIGHT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_WIDTH     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_SCORE     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FRAMES_NEEDED = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REQUIRE_BOTH  = 3'd4;

	localparam int MIN_HEIGHT_RST = 120;
	localparam int MIN_WIDTH_RST  = 12;
	localparam logic [15:0] MIN_SCORE_RST     = 16'd19661;
	localparam logic [7:0]  FRAMES_NEEDED_RST = 8'd2;
	localparam logic        REQUIRE_BOTH_RST  = 1'b1;

	localparam logic [1:0] CLASS_RED   = 2'd1;
	localparam logic [1:0] CLASS_WHITE = 2'd2;

	localparam logic [7:0] STREAK_MAX = 8'hFF;

	typedef struct packed {
		logic red;
		logic white;
		logic empty;
		logic last;
	} tcq_kind_t;

	localparam int KIND_W = $bits(tcq_kind_t);

endpackage

[rtl/tcq_fifo.sv]
// Small register queue used between front and back and at the result side.
// Depends on nothing; DEPTH must be a power of two, at least two.
module tcq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != (AW+1)'(DEPTH)) |-> (wr_ptr_q - rd_ptr_q) == count_q[AW-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/tcq_front.sv]
// Front part: clamps box sizes, applies the score threshold, classifies, forms area.
// Depends on tcq_pkg.
module tcq_front
	import tcq_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic [1:0]              class_code,
	input  logic [15:0]             score,
	input  logic signed [PIXEL_BITS:0] box_width,
	input  logic signed [PIXEL_BITS:0] box_height,
	input  logic                    frame_empty,
	input  logic                    last_in_frame,
	input  logic [15:0]             min_score,
	output tcq_kind_t               kind,
	output logic [PIXEL_BITS-1:0]   w,
	output logic [PIXEL_BITS-1:0]   h,
	output logic [2*PIXEL_BITS-1:0] area
);

	logic hit;

	assign w   = box_width[PIXEL_BITS]  ? '0 : box_width[PIXEL_BITS-1:0];
	assign h   = box_height[PIXEL_BITS] ? '0 : box_height[PIXEL_BITS-1:0];
	assign hit = (score >= min_score);

	assign area = (2*PIXEL_BITS)'(w) * (2*PIXEL_BITS)'(h);

	always_comb begin
		kind.red   = hit && (class_code == CLASS_RED);
		kind.white = hit && (class_code == CLASS_WHITE);
		kind.empty = frame_empty;
		kind.last  = last_in_frame;
	end

endmodule

[rtl/tcq_back.sv]
// Back part: keeps the largest box per class, judges the frame, updates the streak.
// Depends on tcq_pkg.
module tcq_back
	import tcq_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  tcq_kind_t               kind,
	input  logic [PIXEL_BITS-1:0]   w,
	input  logic [PIXEL_BITS-1:0]   h,
	input  logic [2*PIXEL_BITS-1:0] area,
	output logic                    take,
	input  logic [PIXEL_BITS-1:0]   min_height,
	input  logic [PIXEL_BITS-1:0]   min_width,
	input  logic [7:0]              frames_needed,
	input  logic                    require_both,
	input  logic                    out_full,
	output logic                    res_push,
	output logic                    res_pass,
	output logic                    res_good,
	output logic [7:0]              res_streak,
	output logic [PIXEL_BITS-1:0]   res_red_w,
	output logic [PIXEL_BITS-1:0]   res_red_h,
	output logic [PIXEL_BITS-1:0]   res_white_w,
	output logic [PIXEL_BITS-1:0]   res_white_h
);

	logic [PIXEL_BITS-1:0]   red_w_q, red_h_q, white_w_q, white_h_q;
	logic [2*PIXEL_BITS-1:0] red_area_q, white_area_q;
	logic [7:0]              streak_q;

	logic                    red_hit, white_hit, red_big, white_big, good, frame_end;
	logic [PIXEL_BITS-1:0]   red_w_n, red_h_n, white_w_n, white_h_n;
	logic [7:0]              streak_inc, streak_n;

	assign take      = in_valid && !out_full;
	assign frame_end = kind.empty || kind.last;
	assign res_push  = take && frame_end;

	assign red_hit   = kind.red   && (area > red_area_q);
	assign white_hit = kind.white && (area > white_area_q);

	assign red_w_n   = red_hit   ? w : red_w_q;
	assign red_h_n   = red_hit   ? h : red_h_q;
	assign white_w_n = white_hit ? w : white_w_q;
	assign white_h_n = white_hit ? h : white_h_q;

	assign red_big   = (red_w_n >= min_width) && (red_h_n >= min_height);
	assign white_big = (white_w_n >= min_width) && (white_h_n >= min_height);
	assign good      = require_both ? (red_big && white_big) : (red_big || white_big);

	assign streak_inc = (streak_q == STREAK_MAX) ? streak_q : streak_q + 8'd1;
	assign streak_n   = good ? streak_inc : 8'd0;

	always_comb begin
		if (kind.empty) begin
			res_pass    = 1'b0;
			res_good    = 1'b0;
			res_streak  = '0;
			res_red_w   = '0;
			res_red_h   = '0;
			res_white_w = '0;
			res_white_h = '0;
		end else begin
			res_pass    = good && (streak_n >= frames_needed);
			res_good    = good;
			res_streak  = streak_n;
			res_red_w   = red_w_n;
			res_red_h   = red_h_n;
			res_white_w = white_w_n;
			res_white_h = white_h_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_w_q      <= '0;
			red_h_q      <= '0;
			red_area_q   <= '0;
			white_w_q    <= '0;
			white_h_q    <= '0;
			white_area_q <= '0;
			streak_q     <= '0;
		end else if (take) begin
			if (frame_end) begin
				red_w_q      <= '0;
				red_h_q      <= '0;
				red_area_q   <= '0;
				white_w_q    <= '0;
				white_h_q    <= '0;
				white_area_q <= '0;
				streak_q     <= kind.empty ? 8'd0 : streak_n;
			end else begin
				if (red_hit) begin
					red_w_q    <= w;
					red_h_q    <= h;
					red_area_q <= area;
				end
				if (white_hit) begin
					white_w_q    <= w;
					white_h_q    <= h;
					white_area_q <= area;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_pass_good: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_pass) |-> res_good)
		else $error("pass without a good frame");
	a_bad_streak: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_good) |-> (res_streak == 8'd0))
		else $error("streak kept on a bad frame");
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (red_area_q == '0) && (white_area_q == '0))
		else $error("kept boxes not cleared at frame end");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(streak_q) && $stable(red_area_q) && $stable(white_area_q))
		else $error("state moved without a transaction");
`endif

endmodule

[rtl/two_class_detection_size_qualifier.sv]
// Top level of the two-class detection size qualifier.
// Depends on tcq_pkg, tcq_front, tcq_fifo and tcq_back.
//
// Usage:
//   Detections enter through a queue-like port: an input transaction completes
//   at a rising edge with push high and full low. One result per frame leaves
//   through a queue-like port: it is on the result ports while empty is low and
//   is taken at a rising edge with pop high and empty low. Configuration is
//   written through reg_index / write_data at an edge with write_en high; unknown
//   indexes are ignored. The user writes only while the block is idle (unchecked).
// Timing:
//   One detection per cycle is accepted while full is low. The front classifies and
//   forms the box area in the accept cycle and writes a two-entry queue; the back
//   takes one entry per cycle from it while the result queue has room. A result
//   enters the result queue when the back takes the entry that ends its frame.
// Reset and stall:
//   Reset empties both queues, clears the kept boxes and the streak and loads the
//   register defaults. When the receiver stops popping, the two-entry result queue
//   fills, the back holds, the middle queue fills and full rises.
module two_class_detection_size_qualifier
	import tcq_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 class_code,
	input  logic [15:0]                score,
	input  logic signed [PIXEL_BITS:0] box_width,
	input  logic signed [PIXEL_BITS:0] box_height,
	input  logic                       frame_empty,
	input  logic                       last_in_frame,
	input  logic                       pop,
	output logic                       empty,
	output logic                       pass,
	output logic                       frame_good,
	output logic [7:0]                 streak,
	output logic [PIXEL_BITS-1:0]      red_width,
	output logic [PIXEL_BITS-1:0]      red_height,
	output logic [PIXEL_BITS-1:0]      white_width,
	output logic [PIXEL_BITS-1:0]      white_height,
	input  logic                       write_en,
	input  logic [REG_IDX_W-1:0]       reg_index,
	input  logic [CFG_DATA_W-1:0]      write_data
);

	localparam int PB    = PIXEL_BITS;
	localparam int MID_W = KIND_W + 4*PB;
	localparam int RES_W = 10 + 4*PB;

	logic [PB-1:0] min_height_q, min_width_q;
	logic [15:0]   min_score_q;
	logic [7:0]    frames_needed_q;
	logic          require_both_q;

	tcq_kind_t     f_kind, b_kind;
	logic [PB-1:0] f_w, f_h, b_w, b_h;
	logic [2*PB-1:0] f_area, b_area;

	logic [MID_W-1:0] mid_wr, mid_rd;
	logic             mid_empty, b_take;

	logic             res_push, res_pass, res_good, out_full;
	logic [7:0]       res_streak;
	logic [PB-1:0]    res_red_w, res_red_h, res_white_w, res_white_h;
	logic [RES_W-1:0] res_wr, res_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_height_q    <= PB'(MIN_HEIGHT_RST);
			min_width_q     <= PB'(MIN_WIDTH_RST);
			min_score_q     <= MIN_SCORE_RST;
			frames_needed_q <= FRAMES_NEEDED_RST;
			require_both_q  <= REQUIRE_BOTH_RST;
		end else if (write_en) begin
			case (reg_index)
				REG_MIN_HEIGHT:    min_height_q    <= write_data[PB-1:0];
				REG_MIN_WIDTH:     min_width_q     <= write_data[PB-1:0];
				REG_MIN_SCORE:     min_score_q     <= write_data[15:0];
				REG_FRAMES_NEEDED: frames_needed_q <= write_data[7:0];
				REG_REQUIRE_BOTH:  require_both_q  <= write_data[0];
				default: begin
				end
			endcase
		end
	end

	tcq_front #(.PIXEL_BITS(PB)) u_front (
		.class_code    (class_code),
		.score         (score),
		.box_width     (box_width),
		.box_height    (box_height),
		.frame_empty   (frame_empty),
		.last_in_frame (last_in_frame),
		.min_score     (min_score_q),
		.kind          (f_kind),
		.w             (f_w),
		.h             (f_h),
		.area          (f_area)
	);

	assign mid_wr = {f_kind, f_w, f_h, f_area};

	tcq_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (mid_wr),
		.full    (full),
		.pop     (b_take),
		.rd_data (mid_rd),
		.empty   (mid_empty)
	);

	assign b_kind = tcq_kind_t'(mid_rd[MID_W-1 -: KIND_W]);
	assign b_w    = mid_rd[4*PB-1 -: PB];
	assign b_h    = mid_rd[3*PB-1 -: PB];
	assign b_area = mid_rd[2*PB-1:0];

	tcq_back #(.PIXEL_BITS(PB)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (!mid_empty),
		.kind          (b_kind),
		.w             (b_w),
		.h             (b_h),
		.area          (b_area),
		.take          (b_take),
		.min_height    (min_height_q),
		.min_width     (min_width_q),
		.frames_needed (frames_needed_q),
		.require_both  (require_both_q),
		.out_full      (out_full),
		.res_push      (res_push),
		.res_pass      (res_pass),
		.res_good      (res_good),
		.res_streak    (res_streak),
		.res_red_w     (res_red_w),
		.res_red_h     (res_red_h),
		.res_white_w   (res_white_w),
		.res_white_h   (res_white_h)
	);

	assign res_wr = {res_pass, res_good, res_streak,
		res_red_w, res_red_h, res_white_w, res_white_h};

	tcq_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr),
		.full    (out_full),
		.pop     (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign pass         = res_rd[RES_W-1];
	assign frame_good   = res_rd[RES_W-2];
	assign streak       = res_rd[RES_W-3 -: 8];
	assign red_width    = res_rd[4*PB-1 -: PB];
	assign red_height   = res_rd[3*PB-1 -: PB];
	assign white_width  = res_rd[2*PB-1 -: PB];
	assign white_height = res_rd[PB-1:0];

endmodule
